// ===== rtl/core/key_reservation_table_unit_assert.svh =====
// ============================================================================
// key_reservation_table_unit_assert.svh
// Assertion macros used by the reservation table checker (kr_checker).
// ============================================================================
`ifndef KEY_RESERVATION_TABLE_UNIT_ASSERT_SVH
`define KEY_RESERVATION_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define KR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key reservation table check failed");

// Next-cycle implication, disabled while reset is low.
`define KR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key reservation table check failed");

`endif

// ===== rtl/core/kr_pkg.sv =====
// ============================================================================
// kr_pkg
// Types and constants of the key reservation table.
// ============================================================================
package kr_pkg;

    localparam int KR_KEY_SLOTS  = 1024;
    localparam int KR_BLOCK_BITS = 16;
    localparam int KR_COUNT_BITS = 16;

    localparam int SLOT_W   = 10;  // key_slot field
    localparam int BLK_IN_W = 16;  // block_number field
    localparam int OUT_W    = 16;  // result entry fields

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_REL_ONE = 2'd2,
        OP_REL_ALL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_READ_ABORT = 2'd1,
        ST_NOT_OWNER  = 2'd2,
        ST_SATURATED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

endpackage

// ===== rtl/core/kr_stream_if.sv =====
// ============================================================================
// kr_stream_if
// Request and response channels of the key reservation table.
// ============================================================================
interface kr_req_if
    import kr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [SLOT_W-1:0]   key_slot;
    logic [BLK_IN_W-1:0] block_number;

    modport source (output valid, op, key_slot, block_number, input ready);
    modport sink   (input valid, op, key_slot, block_number, output ready);
endinterface

interface kr_rsp_if
    import kr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [OUT_W-1:0] owner_block;
    logic [OUT_W-1:0] pending_writes;
    logic [OUT_W-1:0] waiting_writes;
    logic [OUT_W-1:0] reader_block;

    modport source (output valid, status, owner_block, pending_writes, waiting_writes,
                    reader_block, input ready);
    modport sink   (input valid, status, owner_block, pending_writes, waiting_writes,
                    reader_block, output ready);
endinterface

// ===== rtl/core/kr_entry_ram.sv =====
// ============================================================================
// kr_entry_ram
// Single-port-write, registered-read memory holding the table entries.
// ============================================================================
module kr_entry_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/kr_update.sv =====
// ============================================================================
// kr_update
// Next-entry and status logic for one reservation request.
// ============================================================================
module kr_update
    import kr_pkg::*;
#(
    parameter int BLOCK_BITS = KR_BLOCK_BITS,
    parameter int COUNT_BITS = KR_COUNT_BITS
) (
    input  t_op                   i_op,
    input  logic [BLOCK_BITS-1:0] i_blk,
    input  logic [BLOCK_BITS-1:0] i_owner,
    input  logic [COUNT_BITS-1:0] i_pending,
    input  logic [COUNT_BITS-1:0] i_waiting,
    input  logic [BLOCK_BITS-1:0] i_reader,
    output logic [BLOCK_BITS-1:0] o_owner,
    output logic [COUNT_BITS-1:0] o_pending,
    output logic [COUNT_BITS-1:0] o_waiting,
    output logic [BLOCK_BITS-1:0] o_reader,
    output t_status               o_status
);

    localparam logic [BLOCK_BITS-1:0] BLK_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [BLOCK_BITS-1:0] ho_owner;
    logic [COUNT_BITS-1:0] ho_pending;
    logic [COUNT_BITS-1:0] ho_waiting;
    t_status               ho_status;
    logic [COUNT_BITS-1:0] pend_dec;

    // hand-over to the next block, or free the key
    always_comb begin
        ho_owner   = '0;
        ho_pending = '0;
        ho_waiting = '0;
        ho_status  = ST_OK;
        if (i_waiting != '0) begin
            if (i_owner == BLK_MAX) begin
                ho_status = ST_SATURATED;
            end else begin
                ho_owner   = i_owner + BLOCK_BITS'(1);
                ho_pending = i_waiting;
            end
        end
    end

    assign pend_dec = i_pending - COUNT_BITS'(1);

    always_comb begin
        o_owner   = i_owner;
        o_pending = i_pending;
        o_waiting = i_waiting;
        o_reader  = i_reader;
        o_status  = ST_OK;
        if (i_op == OP_READ) begin
            if (i_owner == '0 || i_owner == i_blk) begin
                if (i_blk > i_reader) begin
                    o_reader = i_blk;
                end
            end else begin
                o_status = ST_READ_ABORT;
            end
        end else if (i_blk == '0) begin
            o_status = ST_NOT_OWNER;
        end else if (i_op == OP_WRITE) begin
            if (i_owner == '0) begin
                o_owner   = i_blk;
                o_pending = COUNT_BITS'(1);
            end else if (i_owner == i_blk) begin
                if (i_pending == CNT_MAX) begin
                    o_status = ST_SATURATED;
                end else begin
                    o_pending = i_pending + COUNT_BITS'(1);
                end
            end else if (i_owner < i_blk) begin
                if (i_waiting == CNT_MAX) begin
                    o_status = ST_SATURATED;
                end else begin
                    o_waiting = i_waiting + COUNT_BITS'(1);
                end
            end else begin
                o_status = ST_NOT_OWNER;
            end
        end else if (i_owner != i_blk) begin
            o_status = ST_NOT_OWNER;
        end else if (i_op == OP_REL_ONE) begin
            if (i_pending == '0) begin
                o_status = ST_SATURATED;
            end else if (pend_dec == '0) begin
                o_owner   = ho_owner;
                o_pending = ho_pending;
                o_waiting = ho_waiting;
                o_status  = ho_status;
            end else begin
                o_pending = pend_dec;
            end
        end else begin
            o_owner   = ho_owner;
            o_pending = ho_pending;
            o_waiting = ho_waiting;
            o_status  = ho_status;
        end
    end

endmodule

// ===== rtl/core/key_reservation_table_unit.sv =====
// ============================================================================
// key_reservation_table_unit
// Per-key write-reservation table with read, write and release requests.
// ============================================================================
// Each request is read synchronously from the entry memory when it is
// accepted in S_IDLE; in S_LOOK the entry is then updated, written back and
// the response is registered, once the response register is free. A new
// request is taken only after the previous entry has been written back, so
// back-to-back requests to the same key always see the updated entry. The
// response register lets the next request start while a response is still
// waiting to be taken. After reset the memory is swept to zero, one entry per
// cycle; no request is accepted during that sweep.
// Slots at or above KEY_SLOTS leave the table untouched and answer with
// status not-owner and all fields zero.
module key_reservation_table_unit
    import kr_pkg::*;
#(
    parameter int KEY_SLOTS  = KR_KEY_SLOTS,
    parameter int BLOCK_BITS = KR_BLOCK_BITS,
    parameter int COUNT_BITS = KR_COUNT_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kr_req_if.sink   i_req,
    kr_rsp_if.source o_rsp
);

    localparam int AW = $clog2(KEY_SLOTS);
    localparam int EW = 2 * BLOCK_BITS + 2 * COUNT_BITS;
    localparam int SW = SLOT_W + AW;   // wide enough for both slot and address

    // ---- control state ----
    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_out_valid;

    // ---- captured request ----
    t_op                   r_op;
    logic [BLOCK_BITS-1:0] r_blk;
    logic                  r_hit;   // slot lies inside the table
    logic [AW-1:0]         r_addr;

    // ---- response register ----
    t_status          r_status;
    logic [OUT_W-1:0] r_owner;
    logic [OUT_W-1:0] r_pending;
    logic [OUT_W-1:0] r_waiting;
    logic [OUT_W-1:0] r_reader;

    logic          in_ready;
    logic          in_accept;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          load_out;

    logic [SW-1:0] slot_wide;
    logic [AW-1:0] req_addr;
    logic          req_hit;

    logic [EW-1:0]         rd_data;
    logic [BLOCK_BITS-1:0] cur_owner, upd_owner;
    logic [COUNT_BITS-1:0] cur_pending, upd_pending;
    logic [COUNT_BITS-1:0] cur_waiting, upd_waiting;
    logic [BLOCK_BITS-1:0] cur_reader, upd_reader;
    t_status               upd_status;

    // Slot to memory address; the compare catches slots past the table end.
    assign slot_wide = SW'(i_req.key_slot);
    assign req_addr  = slot_wide[AW-1:0];
    assign req_hit   = (32'(i_req.key_slot) < 32'(KEY_SLOTS));
    assign in_accept = in_ready && i_req.valid;

    // ---- sequencer: clear sweep, wait for request, look up and update ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_addr;
        wr_data    = {upd_owner, upd_pending, upd_waiting, upd_reader};
        load_out   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(KEY_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) begin
                    rd_en   = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                // entry data is out of the memory; finish once the
                // response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    wr_en    = r_hit;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---- request capture ----
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= t_op'(i_req.op);
            r_blk  <= BLOCK_BITS'(i_req.block_number);
            r_hit  <= req_hit;
            r_addr <= req_addr;
        end
    end

    // ---- entry memory ----
    kr_entry_ram #(
        .DEPTH (KEY_SLOTS),
        .WIDTH (EW),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (req_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // entry layout: {owner, pending, waiting, reader}
    assign cur_owner   = rd_data[EW-1 -: BLOCK_BITS];
    assign cur_pending = rd_data[BLOCK_BITS + 2*COUNT_BITS - 1 -: COUNT_BITS];
    assign cur_waiting = rd_data[BLOCK_BITS + COUNT_BITS - 1 -: COUNT_BITS];
    assign cur_reader  = rd_data[BLOCK_BITS-1:0];

    // ---- update logic ----
    kr_update #(
        .BLOCK_BITS (BLOCK_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .i_op      (r_op),
        .i_blk     (r_blk),
        .i_owner   (cur_owner),
        .i_pending (cur_pending),
        .i_waiting (cur_waiting),
        .i_reader  (cur_reader),
        .o_owner   (upd_owner),
        .o_pending (upd_pending),
        .o_waiting (upd_waiting),
        .o_reader  (upd_reader),
        .o_status  (upd_status)
    );

    // ---- response register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_hit) begin
                r_status  <= upd_status;
                r_owner   <= OUT_W'(upd_owner);
                r_pending <= OUT_W'(upd_pending);
                r_waiting <= OUT_W'(upd_waiting);
                r_reader  <= OUT_W'(upd_reader);
            end else begin
                r_status  <= ST_NOT_OWNER;
                r_owner   <= '0;
                r_pending <= '0;
                r_waiting <= '0;
                r_reader  <= '0;
            end
        end
    end

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.owner_block    = r_owner;
    assign o_rsp.pending_writes = r_pending;
    assign o_rsp.waiting_writes = r_waiting;
    assign o_rsp.reader_block   = r_reader;

endmodule

// ===== rtl/core/kr_checker.sv =====
// ============================================================================
// kr_checker
// Port-level checks of the key reservation table, bound to the top level.
// ============================================================================
`include "key_reservation_table_unit_assert.svh"

module kr_checker
    import kr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       i_status,
    input logic [OUT_W-1:0] i_owner,
    input logic [OUT_W-1:0] i_pending,
    input logic [OUT_W-1:0] i_waiting
);

    // a taken request blocks the next one while it is looked up
    `KR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // a stalled response is not withdrawn
    `KR_ASSERT_NEXT(a_rsp_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a free key carries no outstanding writes
    `KR_ASSERT_IMPL(a_free_no_writes, i_clk, i_rst_n, i_out_valid && i_status == ST_OK && i_owner == '0, i_pending == '0 && i_waiting == '0)

    // a read abort needs a writer on the key
    `KR_ASSERT_IMPL(a_abort_has_owner, i_clk, i_rst_n, i_out_valid && i_status == ST_READ_ABORT, i_owner != '0)

endmodule

bind key_reservation_table_unit kr_checker u_kr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_owner     (o_rsp.owner_block),
    .i_pending   (o_rsp.pending_writes),
    .i_waiting   (o_rsp.waiting_writes)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key reservation table: a shadow table predicts
// every response; random valid/ready idling, a long response hold-off, a
// drain pause and a tail without idling exercise the handshake and state.
// ----------------------------------------------------------------------------
module tb_top;
    import kr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Hold-off of the response side: starts once this many responses are in.
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 250;
    localparam int RAND_ITEMS  = 1775;
    localparam int TAIL_WAIT   = 20;
    localparam int TAIL_WRITES = 24;

    localparam int unsigned BLK_TOP = 32'((64'd1 << KR_BLOCK_BITS) - 64'd1);
    localparam int unsigned CNT_TOP = 32'((64'd1 << KR_COUNT_BITS) - 64'd1);

    // One request item plus the pacing the driver applies before it.
    typedef struct {
        t_op                 op;
        logic [SLOT_W-1:0]   slot;
        logic [BLK_IN_W-1:0] blk;
        int                  gap;    // idle cycles before offering
        bit                  drain;  // wait until all responses are in
        bit                  tail;   // last part of the run: no idling
    } req_item_t;

    // Expected response fields.
    typedef struct {
        t_status          status;
        logic [OUT_W-1:0] owner;
        logic [OUT_W-1:0] pending;
        logic [OUT_W-1:0] waiting;
        logic [OUT_W-1:0] reader;
    } rsp_item_t;

    // Shadow copy of one table entry, at full internal width.
    typedef struct {
        int unsigned owner;
        int unsigned pending;
        int unsigned waiting;
        int unsigned reader;
    } key_entry_t;

    logic i_clk;
    logic i_rst_n;

    kr_req_if req_ch ();
    kr_rsp_if rsp_ch ();

    key_reservation_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    key_entry_t shadow_table [KR_KEY_SLOTS];
    req_item_t  req_pending_q[$];
    rsp_item_t  rsp_expect_q[$];

    int err_count   = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_abort     = 0;
    int n_not_owner = 0;
    int n_saturated = 0;

    // driver state, private to the driver process
    req_item_t staged;
    bit        have_staged = 1'b0;
    int        idle_left   = 0;
    bit        quiet_tail  = 1'b0;

    // receiver state
    int stall_left = 0;
    int calm_left  = 0;
    int hold_left;
    bit hold_done;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------------

    // Release hand-over: the next block (owner + 1) inherits the waiting
    // writes, or the key goes free. A hand-over past the top block number
    // frees the key and flags saturation.
    function automatic t_status pass_key(input key_entry_t e_in, output key_entry_t e_out);
        e_out = e_in;
        if (e_in.waiting > 0) begin
            if (e_in.owner >= BLK_TOP) begin
                e_out.owner   = 0;
                e_out.pending = 0;
                e_out.waiting = 0;
                return ST_SATURATED;
            end
            e_out.owner   = e_in.owner + 1;
            e_out.pending = e_in.waiting;
            e_out.waiting = 0;
        end else begin
            e_out.owner   = 0;
            e_out.pending = 0;
        end
        return ST_OK;
    endfunction

    // Applies one request to the shadow table and returns the response.
    function automatic rsp_item_t reserve_predict(input t_op op,
                                                  input logic [SLOT_W-1:0] slot,
                                                  input logic [BLK_IN_W-1:0] blk_in);
        rsp_item_t   r;
        key_entry_t  e;
        int unsigned blk;
        t_status     st;
        blk = int'(blk_in) & BLK_TOP;
        st  = ST_OK;
        if (int'(slot) >= KR_KEY_SLOTS) begin
            // slot outside the table: nothing changes, all fields zero
            r.status  = ST_NOT_OWNER;
            r.owner   = '0;
            r.pending = '0;
            r.waiting = '0;
            r.reader  = '0;
            return r;
        end
        e = shadow_table[slot];
        if (op == OP_READ) begin
            // read only while unowned or owned by the reader's own block;
            // block zero never raises the reader mark
            if (e.owner == 0 || e.owner == blk) begin
                if (blk > e.reader)
                    e.reader = blk;
            end else begin
                st = ST_READ_ABORT;
            end
        end else if (blk == 0) begin
            st = ST_NOT_OWNER;
        end else if (op == OP_WRITE) begin
            if (e.owner == 0) begin
                e.owner   = blk;
                e.pending = 1;
            end else if (e.owner == blk) begin
                if (e.pending >= CNT_TOP) st = ST_SATURATED;
                else                      e.pending++;
            end else if (e.owner < blk) begin
                if (e.waiting >= CNT_TOP) st = ST_SATURATED;
                else                      e.waiting++;
            end else begin
                st = ST_NOT_OWNER;  // earlier block than the owner
            end
        end else if (e.owner != blk) begin
            st = ST_NOT_OWNER;
        end else if (op == OP_REL_ONE) begin
            if (e.pending == 0) begin
                st = ST_SATURATED;
            end else begin
                e.pending--;
                if (e.pending == 0)
                    st = pass_key(e, e);
            end
        end else begin
            st = pass_key(e, e);
        end
        shadow_table[slot] = e;
        r.status  = st;
        r.owner   = e.owner[OUT_W-1:0];
        r.pending = e.pending[OUT_W-1:0];
        r.waiting = e.waiting[OUT_W-1:0];
        r.reader  = e.reader[OUT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // Predicts at the edge that accepts an item, then stages the next one.
    // Driver-private state is blocking; the channel is driven with NBAs.
    always @(posedge i_clk) begin
        rsp_item_t predicted;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            have_staged = 1'b0;
            idle_left   = 0;
            foreach (shadow_table[i])
                shadow_table[i] = '{0, 0, 0, 0};
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predicted = reserve_predict(t_op'(req_ch.op), req_ch.key_slot,
                                            req_ch.block_number);
                rsp_expect_q = {rsp_expect_q, predicted};
                n_accepted++;
            end
            // an offered item stays put until taken
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (!have_staged && req_pending_q.size() != 0) begin
                    staged      = req_pending_q.pop_front();
                    have_staged = 1'b1;
                    idle_left   = staged.gap;
                end
                if (have_staged && idle_left == 0 &&
                    !(staged.drain && rsp_expect_q.size() != 0)) begin
                    req_ch.valid        <= 1'b1;
                    req_ch.op           <= staged.op;
                    req_ch.key_slot     <= staged.slot;
                    req_ch.block_number <= staged.blk;
                    quiet_tail          <= staged.tail;
                    have_staged = 1'b0;
                end else begin
                    req_ch.valid <= 1'b0;
                    if (have_staged && idle_left != 0)
                        idle_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long response hold-off, counted here in cycles. While it runs the
    // sender keeps offering, so the response register fills and the
    // request side stalls.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic cmp_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Response monitor and ready pacing
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rsp_item_t want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_results++;
                case (t_status'(rsp_ch.status))
                    ST_READ_ABORT: n_abort++;
                    ST_NOT_OWNER:  n_not_owner++;
                    ST_SATURATED:  n_saturated++;
                    default: ;
                endcase
                if (rsp_expect_q.size() == 0) begin
                    $error("response with no request outstanding: status %0d owner %0d",
                           rsp_ch.status, rsp_ch.owner_block);
                    err_count++;
                end else begin
                    want = rsp_expect_q.pop_front();
                    cmp_field("status", OUT_W'(want.status), OUT_W'(rsp_ch.status));
                    cmp_field("owner_block", want.owner, rsp_ch.owner_block);
                    cmp_field("pending_writes", want.pending, rsp_ch.pending_writes);
                    cmp_field("waiting_writes", want.waiting, rsp_ch.waiting_writes);
                    cmp_field("reader_block", want.reader, rsp_ch.reader_block);
                end
            end
            // random stall bursts, with calm stretches in between
            if (hold_left != 0) begin
                rsp_ch.ready <= 1'b0;
            end else if (stall_left != 0 && !quiet_tail) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!quiet_tail && calm_left == 0 && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 14);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (calm_left != 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = $urandom_range(40, 120);
            end
        end
    end

    task automatic queue_req(input t_op op, input int slot, input int blk,
                             input int gap = 0, input bit drain = 1'b0,
                             input bit tail = 1'b0);
        req_item_t it;
        it.op    = op;
        it.slot  = SLOT_W'(slot);
        it.blk   = BLK_IN_W'(blk);
        it.gap   = gap;
        it.drain = drain;
        it.tail  = tail;
        req_pending_q = {req_pending_q, it};
    endtask

    // Timeout guard.
    initial begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int hot_keys [6];
        int n_rand;
        int key;
        int base;
        int len;
        int pick;
        int gap;
        bit calm;
        bit noise;
        bit drain_done;
        t_op op;

        hot_keys   = '{0, 1, 77, 300, 512, KR_KEY_SLOTS - 1};
        n_rand     = 0;
        drain_done = 1'b0;

        i_rst_n <= 1'b0;

        // Directed: block zero, read conflict, earlier-block write, waiting
        // writes and hand-over, release by a non-owner, top slot and top block.
        queue_req(OP_READ,    5, 0);      // block zero read on a free key
        queue_req(OP_WRITE,   5, 0);      // block zero write is refused
        queue_req(OP_REL_ONE, 5, 0);
        queue_req(OP_REL_ALL, 5, 0);
        queue_req(OP_READ,    5, 10);
        queue_req(OP_WRITE,   5, 10);     // claim
        queue_req(OP_WRITE,   5, 10);     // second pending write
        queue_req(OP_READ,    5, 11);     // other block reads: abort
        queue_req(OP_READ,    5, 0);      // block zero on an owned key: abort
        queue_req(OP_WRITE,   5, 9);      // earlier block: refused
        queue_req(OP_WRITE,   5, 12);     // later block waits
        queue_req(OP_REL_ONE, 5, 12);     // non-owner release
        queue_req(OP_REL_ONE, 5, 10);
        queue_req(OP_REL_ONE, 5, 10);     // last write: key passes to 11
        queue_req(OP_REL_ALL, 5, 11);     // nothing waiting: key freed
        queue_req(OP_REL_ONE, 5, 11);     // owner gone
        queue_req(OP_WRITE,   KR_KEY_SLOTS - 1, 65534);
        queue_req(OP_WRITE,   KR_KEY_SLOTS - 1, 65535);
        queue_req(OP_REL_ALL, KR_KEY_SLOTS - 1, 65534);   // owner becomes top block
        queue_req(OP_READ,    KR_KEY_SLOTS - 1, 65535);
        queue_req(OP_REL_ONE, KR_KEY_SLOTS - 1, 65535);
        queue_req(OP_WRITE,   0, 1);
        queue_req(OP_REL_ALL, 0, 1);

        // Random: short reservation sequences on a key from a few blocks
        // close together, mostly on hot keys, with some pure noise.
        while (n_rand < RAND_ITEMS) begin
            key = ($urandom_range(0, 9) < 7) ? hot_keys[$urandom_range(0, 5)]
                                             : $urandom_range(0, KR_KEY_SLOTS - 1);
            case ($urandom_range(0, 7))
                0:       base = $urandom_range(1, 4);
                1:       base = $urandom_range(65530, 65535);
                default: base = $urandom_range(1, 65535);
            endcase
            len   = $urandom_range(4, 14);
            calm  = ($urandom_range(0, 2) == 0);
            noise = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
                gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
                if (noise) begin
                    queue_req(t_op'($urandom_range(0, 3)), $urandom_range(0, KR_KEY_SLOTS - 1),
                              $urandom_range(0, 65535), gap);
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 2 || pick == 9) op = OP_READ;
                    else if (pick < 6)         op = OP_WRITE;
                    else if (pick < 8)         op = OP_REL_ONE;
                    else                       op = OP_REL_ALL;
                    // wraps past the top block into block zero now and then
                    queue_req(op, key, (base + $urandom_range(0, 2)) & 16'hFFFF, gap,
                              !drain_done && n_rand >= RAND_ITEMS / 2);
                    if (!drain_done && n_rand >= RAND_ITEMS / 2)
                        drain_done = 1'b1;
                end
                n_rand++;
            end
        end

        // Tail without idling: one owner piles up pending writes, the next
        // block queues waiting writes, then hand over and free the key.
        // The sender first waits for every outstanding response.
        queue_req(OP_WRITE, 777, 40000, 0, 1'b1, 1'b1);
        for (int k = 0; k < TAIL_WRITES; k++)
            queue_req(OP_WRITE, 777, 40000, 0, 1'b0, 1'b1);
        for (int k = 0; k < TAIL_WRITES; k++)
            queue_req(OP_WRITE, 777, 40001, 0, 1'b0, 1'b1);
        queue_req(OP_REL_ALL, 777, 40000, 0, 1'b0, 1'b1);
        queue_req(OP_REL_ONE, 777, 40001, 0, 1'b0, 1'b1);
        queue_req(OP_REL_ALL, 777, 40001, 0, 1'b0, 1'b1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all items taken, then all responses in, then a short quiet spell
        while (req_pending_q.size() != 0 || have_staged || req_ch.valid)
            @(posedge i_clk);
        while (rsp_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (rsp_expect_q.size() != 0) begin
            $error("%0d responses never arrived", rsp_expect_q.size());
            err_count++;
        end

        $display("run: %0d requests, %0d responses, %0d errors", n_accepted, n_results,
                 err_count);
        $display("statuses seen: %0d read aborts, %0d not-owner, %0d saturated",
                 n_abort, n_not_owner, n_saturated);
        if (err_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/kr_pkg.sv
rtl/core/kr_stream_if.sv
rtl/core/kr_entry_ram.sv
rtl/core/kr_update.sv
rtl/core/key_reservation_table_unit.sv
rtl/core/kr_checker.sv
tb/sv/tb_top.sv
